/* hw/rtl/rout_pkg.sv */
// Shared types and constants for the resource owner / usage tracker.
package rout_pkg;

    localparam int CNT_W     = 16;
    localparam int TID_W     = 16;
    localparam int RID_W     = 8;
    localparam int MASK_W    = 32;
    localparam int BIT_IDX_W = $clog2(MASK_W);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_PEEK    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] usage;
        logic [TID_W-1:0] owner;
        logic [CNT_W-1:0] contention;
    } t_entry;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

/* hw/rtl/rout_mem.sv */
// Entry table: synchronous memory with per-entry valid bits for reset-to-zero.
module rout_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output rout_pkg::t_entry     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  rout_pkg::t_entry     i_wr_data
);
    import rout_pkg::*;

    t_entry             mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* hw/rtl/rout_upd.sv */
// Entry update logic: applies one command to a fetched entry.
module rout_upd (
    input  logic [1:0]                       i_cmd,
    input  logic                             i_id_ok,
    input  logic [rout_pkg::BIT_IDX_W-1:0]   i_bit_idx,
    input  logic [rout_pkg::TID_W-1:0]       i_task_id,
    input  logic [rout_pkg::MASK_W-1:0]      i_task_mask,
    input  rout_pkg::t_entry                 i_entry,
    output rout_pkg::t_entry                 o_entry,
    output logic                             o_wr_en,
    output rout_pkg::t_entry                 o_result,
    output logic [rout_pkg::MASK_W-1:0]      o_task_mask
);
    import rout_pkg::*;

    t_cmd              cmd;
    logic [MASK_W-1:0] bit_sel;
    t_entry            upd;
    logic [MASK_W-1:0] mask_upd;

    assign cmd     = t_cmd'(i_cmd);
    assign bit_sel = {{(MASK_W-1){1'b0}}, 1'b1} << i_bit_idx;

    always_comb begin
        upd      = i_entry;
        mask_upd = i_task_mask;
        unique case (cmd)
            CMD_ACQUIRE: begin
                if (i_entry.usage != CNT_MAX) begin
                    upd.usage = i_entry.usage + 1'b1;
                end
                upd.owner = i_task_id;
                mask_upd  = i_task_mask | bit_sel;
            end
            CMD_RELEASE: begin
                if (i_entry.usage != '0) begin
                    upd.usage = i_entry.usage - 1'b1;
                end
                if (i_entry.owner == i_task_id) begin
                    upd.owner = '0;
                end
                mask_upd = i_task_mask & ~bit_sel;
            end
            CMD_QUERY: begin
                if (i_entry.usage > CNT_W'(1) && i_entry.contention != CNT_MAX) begin
                    upd.contention = i_entry.contention + 1'b1;
                end
            end
            default: begin
                // read-only look, entry untouched
            end
        endcase
    end

    assign o_entry     = upd;
    assign o_wr_en     = i_id_ok && (cmd != CMD_PEEK);
    assign o_result    = i_id_ok ? upd : '0;
    assign o_task_mask = i_id_ok ? mask_upd : i_task_mask;

endmodule

/* hw/rtl/resource_owner_usage_tracker.sv */
// Top level of the resource owner / usage tracker: sequencer and result register.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_cmd i_resource_id i_task_id i_task_mask
//  out       output     o_out_valid / i_out_ready o_id_valid o_usage_count o_owner_id
//                                                 o_contention_total o_new_task_mask
//
// Each transaction reads its entry from the table memory, then, once the registered
// read data is there, does update, write-back and result capture.
// Reset (synchronous, active low) marks all entries unwritten; they read as zero.
// A new transaction is taken while a result waits; the update holds until the
// result register is free.
module resource_owner_usage_tracker #(
    parameter int NUM_RESOURCES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_cmd,
    input  logic [rout_pkg::RID_W-1:0]       i_resource_id,
    input  logic [rout_pkg::TID_W-1:0]       i_task_id,
    input  logic [rout_pkg::MASK_W-1:0]      i_task_mask,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_id_valid,
    output logic [rout_pkg::CNT_W-1:0]       o_usage_count,
    output logic [rout_pkg::TID_W-1:0]       o_owner_id,
    output logic [rout_pkg::CNT_W-1:0]       o_contention_total,
    output logic [rout_pkg::MASK_W-1:0]      o_new_task_mask
);
    import rout_pkg::*;

    localparam int AW = $clog2(NUM_RESOURCES);

    t_state             r_state, n_state;
    logic               in_acc;
    logic               exec_go;

    logic [1:0]         r_cmd;
    logic [RID_W-1:0]   r_rid;
    logic [TID_W-1:0]   r_tid;
    logic [MASK_W-1:0]  r_mask;
    logic               r_id_ok;

    t_entry             rd_entry;
    t_entry             wr_entry;
    t_entry             res_entry;
    logic               upd_wr_en;
    logic [MASK_W-1:0]  upd_mask;

    logic               r_out_valid;
    t_entry             r_res;
    logic               r_res_ok;
    logic [MASK_W-1:0]  r_res_mask;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc)  n_state = ST_EXEC;
            ST_EXEC: if (exec_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        exec_go    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: exec_go    = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd;
            r_rid   <= i_resource_id;
            r_tid   <= i_task_id;
            r_mask  <= i_task_mask;
            r_id_ok <= i_resource_id < RID_W'(NUM_RESOURCES);
        end
    end

    rout_mem #(
        .DEPTH (NUM_RESOURCES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_resource_id[AW-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (exec_go && upd_wr_en),
        .i_wr_addr (r_rid[AW-1:0]),
        .i_wr_data (wr_entry)
    );

    rout_upd u_upd (
        .i_cmd       (r_cmd),
        .i_id_ok     (r_id_ok),
        .i_bit_idx   (r_rid[BIT_IDX_W-1:0]),
        .i_task_id   (r_tid),
        .i_task_mask (r_mask),
        .i_entry     (rd_entry),
        .o_entry     (wr_entry),
        .o_wr_en     (upd_wr_en),
        .o_result    (res_entry),
        .o_task_mask (upd_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_res      <= res_entry;
            r_res_ok   <= r_id_ok;
            r_res_mask <= upd_mask;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_id_valid         = r_res_ok;
    assign o_usage_count      = r_res.usage;
    assign o_owner_id         = r_res.owner;
    assign o_contention_total = r_res.contention;
    assign o_new_task_mask    = r_res_mask;

endmodule

/* test/resource_owner_usage_tracker_tb.sv */
// Self-checking testbench for the resource owner / usage tracker.
`timescale 1ns / 100ps

module resource_owner_usage_tracker_tb;
    import rout_pkg::*;

    localparam int NUM_RES    = 32;
    localparam int MAX_STALL  = 25;
    localparam int HOT_RID    = 7;
    localparam int HOT_LEN    = 200;
    localparam int RAND_ITEMS = 1550;

    typedef struct packed {
        t_cmd              cmd;
        logic [RID_W-1:0]  rid;
        logic [TID_W-1:0]  tid;
        logic [MASK_W-1:0] mask;
        logic [7:0]        gap;
    } t_txn;

    typedef struct packed {
        logic              id_valid;
        logic [CNT_W-1:0]  usage;
        logic [TID_W-1:0]  owner;
        logic [CNT_W-1:0]  contention;
        logic [MASK_W-1:0] mask;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_cmd;
    logic [RID_W-1:0]  i_resource_id;
    logic [TID_W-1:0]  i_task_id;
    logic [MASK_W-1:0] i_task_mask;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_id_valid;
    logic [CNT_W-1:0]  o_usage_count;
    logic [TID_W-1:0]  o_owner_id;
    logic [CNT_W-1:0]  o_contention_total;
    logic [MASK_W-1:0] o_new_task_mask;

    resource_owner_usage_tracker #(
        .NUM_RESOURCES(NUM_RES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_resource_id      (i_resource_id),
        .i_task_id          (i_task_id),
        .i_task_mask        (i_task_mask),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_id_valid         (o_id_valid),
        .o_usage_count      (o_usage_count),
        .o_owner_id         (o_owner_id),
        .o_contention_total (o_contention_total),
        .o_new_task_mask    (o_new_task_mask)
    );

    // shadow copy of the resource table
    logic [CNT_W-1:0] usage_tab      [NUM_RES];
    logic [TID_W-1:0] owner_tab      [NUM_RES];
    logic [CNT_W-1:0] contention_tab [NUM_RES];

    t_txn    txn_queue[$];
    t_result owed_results[$];
    int      err_cnt      = 0;
    longint  cycle_cnt    = 0;
    longint  cycle_budget = 0;
    longint  limit_cycles = 64'd1_000_000_000;
    int      gen_quiet    = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        else if (r < 90) return $urandom_range(3, 1);
        else return $urandom_range(MAX_STALL, 6);
    endfunction

    // sender gap with occasional back-to-back stretches
    function automatic int unsigned next_in_gap();
        if (gen_quiet != 0) begin
            gen_quiet--;
            return 0;
        end
        if ($urandom_range(29) == 0) begin
            gen_quiet = $urandom_range(150, 30);
            return 0;
        end
        return pick_gap();
    endfunction

    task automatic add_txn(t_cmd c, int unsigned rid, int unsigned tid,
                           logic [MASK_W-1:0] m, int unsigned gap);
        t_txn t;
        t.cmd  = c;
        t.rid  = RID_W'(rid);
        t.tid  = TID_W'(tid);
        t.mask = m;
        t.gap  = 8'(gap);
        txn_queue.push_back(t);
        cycle_budget += gap + MAX_STALL + 8;
    endtask

    function automatic t_result track_update(t_txn t);
        t_result           r;
        logic [MASK_W-1:0] bitsel;
        int                idx;
        r      = '0;
        r.mask = t.mask;
        if (t.rid >= NUM_RES) return r;
        idx    = int'(t.rid);
        bitsel = MASK_W'(1) << t.rid[BIT_IDX_W-1:0];
        case (t.cmd)
            CMD_ACQUIRE: begin
                if (usage_tab[idx] != CNT_MAX) usage_tab[idx] = usage_tab[idx] + 1'b1;
                owner_tab[idx] = t.tid;
                r.mask = t.mask | bitsel;
            end
            CMD_RELEASE: begin
                if (usage_tab[idx] != '0) usage_tab[idx] = usage_tab[idx] - 1'b1;
                if (owner_tab[idx] == t.tid) owner_tab[idx] = '0;
                r.mask = t.mask & ~bitsel;
            end
            CMD_QUERY: begin
                if (usage_tab[idx] > 1 && contention_tab[idx] != CNT_MAX)
                    contention_tab[idx] = contention_tab[idx] + 1'b1;
            end
            default: ;  // peek: read-only
        endcase
        r.id_valid   = 1'b1;
        r.usage      = usage_tab[idx];
        r.owner      = owner_tab[idx];
        r.contention = contention_tab[idx];
        return r;
    endfunction

    task automatic check_field(string name, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // driver
    t_txn        cur_txn;
    logic        in_taken   = 1'b0;
    logic        gap_loaded = 1'b0;
    int unsigned in_idle    = 0;

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            owed_results.push_back(track_update(cur_txn));
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (!gap_loaded && txn_queue.size() != 0) begin
                in_idle    = txn_queue[0].gap;
                gap_loaded = 1'b1;
            end
            if (txn_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (in_idle != 0) begin
                in_idle--;
                i_in_valid <= 1'b0;
            end else begin
                cur_txn       = txn_queue.pop_front();
                gap_loaded    = 1'b0;
                i_cmd         <= cur_txn.cmd;
                i_resource_id <= cur_txn.rid;
                i_task_id     <= cur_txn.tid;
                i_task_mask   <= cur_txn.mask;
                i_in_valid    <= 1'b1;
            end
        end
    end

    // monitor
    t_result     seen_result;
    logic        seen      = 1'b0;
    int unsigned out_stall = 0;
    int unsigned out_quiet = 0;

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            seen_result.id_valid   = o_id_valid;
            seen_result.usage      = o_usage_count;
            seen_result.owner      = o_owner_id;
            seen_result.contention = o_contention_total;
            seen_result.mask       = o_new_task_mask;
            seen = 1'b1;
        end
    end

    // compare at the falling edge so the prediction from the same rising edge is in place
    always @(negedge i_clk) begin
        t_result want;
        if (seen) begin
            seen = 1'b0;
            if (owed_results.size() == 0) begin
                $error("result transaction with no expected result pending");
                err_cnt++;
            end else begin
                want = owed_results.pop_front();
                check_field("id_valid", MASK_W'(want.id_valid), MASK_W'(seen_result.id_valid));
                check_field("usage_count", MASK_W'(want.usage), MASK_W'(seen_result.usage));
                check_field("owner_id", MASK_W'(want.owner), MASK_W'(seen_result.owner));
                check_field("contention_total", MASK_W'(want.contention),
                            MASK_W'(seen_result.contention));
                check_field("new_task_mask", want.mask, seen_result.mask);
            end
        end
        if (i_rst_n) begin
            if (out_stall != 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (out_quiet != 0) out_quiet--;
                else if ($urandom_range(3) == 0) out_stall = pick_gap();
                else if ($urandom_range(199) == 0) out_quiet = $urandom_range(300, 50);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > limit_cycles) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned       r;
        int unsigned       rid;
        int unsigned       tid;
        t_cmd              c;
        logic [TID_W-1:0]  task_pool [4];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = '0;
        i_resource_id = '0;
        i_task_id     = '0;
        i_task_mask   = '0;
        i_out_ready   = 1'b0;
        task_pool     = '{16'h0001, 16'h00FF, 16'hBEEF, 16'h8000};
        for (int i = 0; i < NUM_RES; i++) begin
            usage_tab[i]      = '0;
            owner_tab[i]      = '0;
            contention_tab[i] = '0;
        end

        // directed: empty entries, owner handling, release at zero, edges of every field
        add_txn(CMD_QUERY,   0,   16'h0000, 32'h0000_0000, next_in_gap());
        add_txn(CMD_PEEK,    0,   16'h0000, 32'h0000_0000, next_in_gap());
        add_txn(CMD_ACQUIRE, 0,   16'hFFFF, 32'h0000_0000, next_in_gap());
        add_txn(CMD_ACQUIRE, 0,   16'h1234, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_QUERY,   0,   16'h0000, 32'h1357_9BDF, next_in_gap());
        add_txn(CMD_PEEK,    0,   16'hFFFF, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_RELEASE, 0,   16'hFFFF, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_RELEASE, 0,   16'h1234, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_RELEASE, 0,   16'h0000, 32'h0000_0001, next_in_gap());
        add_txn(CMD_RELEASE, 31,  16'h0000, 32'h8000_0000, next_in_gap());
        add_txn(CMD_ACQUIRE, 31,  16'h0000, 32'h0000_0000, next_in_gap());
        add_txn(CMD_RELEASE, 31,  16'h0000, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_ACQUIRE, 32,  16'h4321, 32'hDEAD_BEEF, next_in_gap());
        add_txn(CMD_RELEASE, 255, 16'hFFFF, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_QUERY,   128, 16'h0001, 32'h0000_0000, next_in_gap());
        add_txn(CMD_PEEK,    33,  16'h8000, 32'h0F0F_0F0F, next_in_gap());
        add_txn(CMD_ACQUIRE, 1,   16'hAAAA, 32'h5555_5555, next_in_gap());
        add_txn(CMD_QUERY,   1,   16'h0000, 32'h0000_0000, next_in_gap());
        add_txn(CMD_ACQUIRE, 16,  16'h5555, 32'hAAAA_AAAA, next_in_gap());
        add_txn(CMD_ACQUIRE, 16,  16'h7FFF, 32'h0000_0000, next_in_gap());
        add_txn(CMD_ACQUIRE, 16,  16'h0100, 32'h0000_0000, next_in_gap());
        add_txn(CMD_QUERY,   16,  16'h0000, 32'hFFFF_FFFF, next_in_gap());
        add_txn(CMD_RELEASE, 16,  16'h5555, 32'h0001_0000, next_in_gap());

        // back-to-back acquires on one entry, then queries that grow its contention
        for (int i = 0; i < HOT_LEN; i++)
            add_txn(CMD_ACQUIRE, HOT_RID, $urandom_range(65535), $urandom(), 0);
        for (int i = 0; i < HOT_LEN; i++)
            add_txn(CMD_QUERY, HOT_RID, $urandom_range(65535), $urandom(), 0);
        add_txn(CMD_RELEASE, HOT_RID, 16'h0000, 32'hFFFF_FFFF, 0);
        add_txn(CMD_PEEK,    HOT_RID, 16'h0000, 32'h0000_0000, 0);

        // random: bias toward a few hot entries and a small task pool
        for (int i = 0; i < RAND_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 35) c = CMD_ACQUIRE;
            else if (r < 65) c = CMD_RELEASE;
            else if (r < 90) c = CMD_QUERY;
            else c = CMD_PEEK;
            r = $urandom_range(99);
            if (r < 45) rid = $urandom_range(3);
            else if (r < 88) rid = $urandom_range(NUM_RES - 1);
            else rid = $urandom_range(255, NUM_RES);
            r = $urandom_range(99);
            if (r < 70) tid = task_pool[$urandom_range(3)];
            else if (r < 85) tid = 0;
            else tid = $urandom_range(65535);
            add_txn(c, rid, tid, $urandom(), next_in_gap());
        end
        limit_cycles = 4 * cycle_budget + 2000;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (txn_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
